// ===== rtl/ijd_pkg.sv =====
`timescale 1ns / 1ps

package ijd_pkg;

	// Raw sample and fixed-point baseline formats
	localparam int SMP_W     = 16;
	localparam int FRAC_W    = 17;
	localparam int BASE_W    = SMP_W + FRAC_W;   // signed 16.17
	localparam int THR_W     = 34;
	localparam int SHIFT_W   = 5;
	localparam int HOLD_W    = 4;

	localparam int MAX_AXES  = 3;
	localparam int AXES_DEF  = 3;
	localparam int NUM_SENSORS = 2;

	// Samples skipped after a jump (0..15)
	localparam int HOLDOFF_ITEMS = 5;

	// Smoothing shift limits
	localparam int SHIFT_MIN = 1;
	localparam int SHIFT_MAX = 24;

	// Register reset values
	localparam logic [THR_W-1:0]   ACCEL_THR_RST = THR_W'(150994944);
	localparam logic [THR_W-1:0]   GYRO_THR_RST  = THR_W'(352450);
	localparam logic [SHIFT_W-1:0] SHIFT_RST     = SHIFT_W'(17);

	typedef logic signed [SMP_W-1:0]  smp_t;
	typedef logic signed [BASE_W-1:0] base_t;
	typedef logic [THR_W-1:0]         thr_t;   // also squared distance
	typedef logic [SHIFT_W-1:0]       shift_t;
	typedef logic [HOLD_W-1:0]        hold_t;

	// Register indexes on the config port
	typedef enum logic [1:0] {
		CFG_ACCEL_THR = 2'd0,
		CFG_GYRO_THR  = 2'd1,
		CFG_SHIFT     = 2'd2
	} cfg_idx_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_SEED  = 2'd0,
		ST_HOLD  = 2'd1,
		ST_QUIET = 2'd2,
		ST_JUMP  = 2'd3
	} status_t;

	// Register set as seen by the datapath (shift already clamped)
	typedef struct packed {
		thr_t   accel_thr;
		thr_t   gyro_thr;
		shift_t shift;
	} cfg_t;

endpackage

// ===== rtl/imu_jump_detector_unit.sv =====
`timescale 1ns / 1ps

// IMU jump detector.
// Input channel (in_valid/in_ready): one three-axis sample per item, op
// selects accelerometer (0) or gyroscope (1). Output channel
// (out_valid/out_ready): one result item per input item, jump and status.
// Config channel (cfg_valid/cfg_ready): cfg_index picks accel threshold,
// gyro threshold or smoothing shift; always ready, write only while idle.
// Items go through the input and result registers. One item per cycle
// while out_ready is high; the per-sensor baseline and the shared
// hold-off counter are read and updated in the same cycle, so a sample
// in the input register always sees what the previous one left behind.
// Datapath: three 17x17 squares, a 34-bit sum and compare, one barrel
// shift and add per axis, all between the input and result registers.
// Reset clears baselines, arms the first-sample flag, zeroes hold-off and
// loads the default registers. When out_ready is low the result register
// holds; one more item is taken into the input register, then in_ready
// drops until the result is taken.
module imu_jump_detector_unit #(
	parameter int AXES = ijd_pkg::AXES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// input items
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      op,
	input  logic signed [15:0]        sample_x,
	input  logic signed [15:0]        sample_y,
	input  logic signed [15:0]        sample_z,
	// result items
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      jump,
	output logic [1:0]                status,
	// register writes
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [ijd_pkg::THR_W-1:0] cfg_data
);
	import ijd_pkg::*;

	// input register
	logic  valid_s1;
	logic  op_s1;
	smp_t  smp_s1 [MAX_AXES];

	// result register
	logic    jump_q;
	status_t status_q;

	cfg_t    cfg;
	logic    advance;
	logic    core_jump;
	status_t core_status;

	assign cfg_ready = 1'b1;

	ijd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// the input register moves on when the result register is free
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1     <= op;
			smp_s1[0] <= sample_x;
			smp_s1[1] <= sample_y;
			smp_s1[2] <= sample_z;
		end
	end

	ijd_core #(
		.AXES (AXES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.op     (op_s1),
		.sample (smp_s1),
		.cfg    (cfg),
		.jump   (core_jump),
		.status (core_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			jump_q   <= core_jump;
			status_q <= core_status;
		end
	end

	assign jump   = jump_q;
	assign status = status_q;

endmodule

// ===== rtl/ijd_cfg_regs.sv =====
`timescale 1ns / 1ps

module ijd_cfg_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [1:0]            wr_index,
	input  logic [ijd_pkg::THR_W-1:0] wr_data,
	output ijd_pkg::cfg_t         cfg
);
	import ijd_pkg::*;

	thr_t   accel_thr_q;
	thr_t   gyro_thr_q;
	shift_t shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_thr_q <= ACCEL_THR_RST;
			gyro_thr_q  <= GYRO_THR_RST;
			shift_q     <= SHIFT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_ACCEL_THR: accel_thr_q <= wr_data;
				CFG_GYRO_THR:  gyro_thr_q  <= wr_data;
				CFG_SHIFT:     shift_q     <= wr_data[SHIFT_W-1:0];
				default: ;     // unmapped index, write dropped
			endcase
		end
	end

	// clamp shift into its legal range
	always_comb begin
		cfg.accel_thr = accel_thr_q;
		cfg.gyro_thr  = gyro_thr_q;
		if (shift_q < SHIFT_W'(SHIFT_MIN))
			cfg.shift = SHIFT_W'(SHIFT_MIN);
		else if (shift_q > SHIFT_W'(SHIFT_MAX))
			cfg.shift = SHIFT_W'(SHIFT_MAX);
		else
			cfg.shift = shift_q;
	end

endmodule

// ===== rtl/ijd_core.sv =====
`timescale 1ns / 1ps

module ijd_core #(
	parameter int AXES = ijd_pkg::AXES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             op,
	input  ijd_pkg::smp_t    sample [ijd_pkg::MAX_AXES],
	input  ijd_pkg::cfg_t    cfg,
	output logic             jump,
	output ijd_pkg::status_t status
);
	import ijd_pkg::*;

	localparam hold_t HOLD_INIT = hold_t'(HOLDOFF_ITEMS);

	// baselines: index 0 accelerometer, 1 gyroscope
	base_t base_q [NUM_SENSORS][AXES];
	logic  first_q;
	hold_t hold_q;

	thr_t  sq      [AXES];
	base_t seed    [AXES];
	base_t nb      [AXES];
	thr_t  sq_sum;
	thr_t  thr;

	for (genvar i = 0; i < AXES; i++) begin : g_axis
		base_t                   cur;
		logic signed [SMP_W:0]   d;
		logic signed [2*SMP_W+1:0] prod;
		logic signed [BASE_W:0]  diff;
		logic signed [BASE_W:0]  delta;

		assign cur  = base_q[op][i];
		// distance to the integer part of the baseline (floor)
		assign d    = {sample[i][SMP_W-1], sample[i]} - {cur[BASE_W-1], cur[BASE_W-1:FRAC_W]};
		assign prod = d * d;
		assign sq[i] = {2'b00, prod[2*SMP_W-1:0]};
		// moving average update, arithmetic shift gives floor
		assign seed[i]  = {sample[i], {FRAC_W{1'b0}}};
		assign diff     = {seed[i][BASE_W-1], seed[i]} - {cur[BASE_W-1], cur};
		assign delta    = diff >>> cfg.shift;
		assign nb[i]    = cur + delta[BASE_W-1:0];
	end

	always_comb begin
		sq_sum = '0;
		for (int i = 0; i < AXES; i++)
			sq_sum = sq_sum + sq[i];
	end

	assign thr = op ? cfg.gyro_thr : cfg.accel_thr;

	always_comb begin
		priority if (first_q)
			status = ST_SEED;
		else if (hold_q != '0)
			status = ST_HOLD;
		else if (sq_sum > thr)
			status = ST_JUMP;
		else
			status = ST_QUIET;
	end

	assign jump = (status == ST_JUMP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SENSORS; s++)
				for (int i = 0; i < AXES; i++)
					base_q[s][i] <= '0;
			first_q <= 1'b1;
			hold_q  <= '0;
		end else if (step) begin
			unique case (status)
				ST_SEED: begin
					first_q <= 1'b0;
					for (int i = 0; i < AXES; i++)
						base_q[op][i] <= seed[i];
				end
				ST_HOLD: begin
					hold_q <= hold_q - 1'b1;
				end
				ST_JUMP: begin
					hold_q <= HOLD_INIT;
				end
				ST_QUIET: begin
					for (int i = 0; i < AXES; i++)
						base_q[op][i] <= nb[i];
				end
				default: ;
			endcase
		end
	end

endmodule
